// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- sv/cmm_pkg.sv -----
package cmm_pkg;
    localparam int COLOR_ENTRIES_DEF = 16;
    localparam int HISTORY_DEPTH_DEF = 16;

    localparam int RAW_W   = 12;
    localparam int NORM_W  = 8;
    localparam int SLOT_W  = 4;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 12;
    localparam int LIMIT_W = 8;
    localparam int DLIM_W  = 9;
    localparam int MAG_W   = 9;

    // register indexes
    localparam logic [CFG_IW-1:0] CFG_FULL_SCALE   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_MATCH_LIMIT  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_MATCH_ENABLE = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DELTA_ENABLE = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_DELTA_LIMIT  = 3'd4;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_STORE   = 1'b1;

    localparam logic KIND_MATCH  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [RAW_W-1:0] FULL_SCALE_RST = 12'd4095;
endpackage

// ----- sv/cmm_ram.sv -----
module cmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/color_measure_match.sv -----
// Color measure and match. A store transaction (opcode 1) writes one color
// table entry. A measure transaction normalizes the three raw readings to
// floor(raw*255/full_scale), saturated at 255, with three restoring dividers
// running side by side. In delta mode the magnitude sqrt(r^2+g^2+b^2) is
// found bit-serially, pushed into the history memory, and the running average
// is formed by two reciprocal multiplications (sum/HISTORY_DEPTH, then /10).
// With matching on, the color table memory is walked one entry at a time,
// each entry read, squared and compared in turn. An output stall can hold a
// measure up; the block takes one transaction at a time. Table and history
// contents are qualified by valid flops cleared at reset, so no clearing pass
// is needed. The output register lets the final result wait while the next
// transaction is accepted.
module color_measure_match
    import cmm_pkg::*;
#(
    parameter int COLOR_ENTRIES = cmm_pkg::COLOR_ENTRIES_DEF,
    parameter int HISTORY_DEPTH = cmm_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cmm_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [cmm_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [cmm_pkg::RAW_W-1:0]   i_raw_red,
    input  logic [cmm_pkg::RAW_W-1:0]   i_raw_green,
    input  logic [cmm_pkg::RAW_W-1:0]   i_raw_blue,
    input  logic [cmm_pkg::SLOT_W-1:0]  i_entry_slot,
    input  logic [cmm_pkg::NORM_W-1:0]  i_entry_red,
    input  logic [cmm_pkg::NORM_W-1:0]  i_entry_green,
    input  logic [cmm_pkg::NORM_W-1:0]  i_entry_blue,
    input  logic                        i_entry_valid,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_kind,
    output logic [cmm_pkg::NORM_W-1:0]  o_norm_red,
    output logic [cmm_pkg::NORM_W-1:0]  o_norm_green,
    output logic [cmm_pkg::NORM_W-1:0]  o_norm_blue,
    output logic [cmm_pkg::SLOT_W-1:0]  o_matched_slot,
    output logic                        o_last
);
    `include "assert_macros.svh"

    localparam int TAW   = (COLOR_ENTRIES > 1) ? $clog2(COLOR_ENTRIES) : 1;
    localparam int TIW   = $clog2(COLOR_ENTRIES + 1);
    localparam int HAW   = $clog2(HISTORY_DEPTH);
    localparam int SUMW  = MAG_W + $clog2(HISTORY_DEPTH);
    localparam int DVDW  = 20;
    localparam int DIV_STEPS = DVDW;
    localparam int ROOT_STEPS = 10;
    localparam int CNTW  = 5;
    localparam int TBLW  = 3 * NORM_W;
    localparam int SQW   = 2 * NORM_W;
    localparam int D2W   = SQW + 2;
    localparam int RTW   = 20;
    localparam int SIW   = 7;
    localparam logic [SIW-1:0] ENTRIES_V = SIW'(COLOR_ENTRIES);
    // reciprocal of HISTORY_DEPTH, exact for every sum below 2^SUMW
    localparam int QSH   = SUMW + HAW;
    localparam int QMUL  = (2**QSH + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
    localparam int QPW   = SUMW + QSH;
    // reciprocal of 10, exact for every 13-bit dividend
    localparam int AVW   = 13;
    localparam int ASH   = 17;
    localparam int AMUL  = (2**ASH + 9) / 10;
    localparam int APW   = AVW + ASH;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NORM = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_ROOT = 4'd3;
    localparam logic [3:0] S_HSUM = 4'd4;
    localparam logic [3:0] S_DIVQ = 4'd5;
    localparam logic [3:0] S_AVG  = 4'd6;
    localparam logic [3:0] S_DIFF = 4'd8;
    localparam logic [3:0] S_MRD  = 4'd9;
    localparam logic [3:0] S_MSQ  = 4'd10;
    localparam logic [3:0] S_MCMP = 4'd11;
    localparam logic [3:0] S_REP  = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    // configuration
    logic [RAW_W-1:0]   r_full_scale;
    logic [LIMIT_W-1:0] r_match_limit;
    logic               r_match_enable;
    logic               r_delta_enable;
    logic [DLIM_W-1:0]  r_delta_limit;

    logic [3:0]         r_state;
    logic [CNTW-1:0]    r_cnt;

    // divider lanes
    logic [DVDW-1:0]    r_dvd [3];
    logic [RAW_W-1:0]   r_rem [3];
    logic [RAW_W-1:0]   r_dsr [3];
    logic [DVDW-1:0]    n_dvd [3];
    logic [RAW_W-1:0]   n_rem [3];

    logic [NORM_W-1:0]  r_n [3];
    logic [NORM_W-1:0]  sat [3];

    // magnitude
    logic [RTW-1:0]     r_sx;
    logic [RTW-1:0]     r_res;
    logic [RTW-1:0]     r_bit;
    logic [RTW-1:0]     root_try;
    logic               r_old_v;
    logic [SUMW-1:0]    r_hsum;
    logic [HAW-1:0]     r_hptr;
    logic               r_hval [HISTORY_DEPTH];
    logic [MAG_W-1:0]   mag;
    logic [MAG_W-1:0]   old_mag;
    logic [SUMW-1:0]    sum_new;
    logic [QPW-1:0]     q_prod;
    logic [MAG_W-1:0]   r_q;
    logic [AVW-1:0]     avg_dvd;
    logic [APW-1:0]     a_prod;
    logic [MAG_W-1:0]   avg;
    logic [MAG_W-1:0]   r_avg;
    logic [MAG_W-1:0]   diff;

    // table walk
    logic               r_tval [COLOR_ENTRIES];
    logic [TIW-1:0]     r_idx;
    logic [SQW-1:0]     r_sq [3];
    logic [SQW-1:0]     r_lim2;
    logic               r_report;
    logic [D2W-1:0]     d2;
    logic [NORM_W-1:0]  ent [3];
    logic [NORM_W-1:0]  ad [3];

    // pending result and output register
    logic               r_pend_v;
    logic               r_pend_kind;
    logic [SLOT_W-1:0]  r_pend_slot;
    logic               r_o_valid;
    logic               r_o_kind;
    logic [NORM_W-1:0]  r_o_n [3];
    logic [SLOT_W-1:0]  r_o_slot;
    logic               r_o_last;

    logic               out_free;
    logic               can_push;
    logic               in_acc;
    logic               store_hit;

    // memories
    logic               tbl_we;
    logic               tbl_re;
    logic [TBLW-1:0]    tbl_rdata;
    logic               hist_we;
    logic               hist_re;
    logic [MAG_W-1:0]   hist_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign store_hit   = {{(SIW-SLOT_W){1'b0}}, i_entry_slot} < ENTRIES_V;
    assign tbl_we      = in_acc && (i_opcode == OP_STORE) && store_hit;
    assign tbl_re      = (r_state == S_MRD);
    assign hist_re     = (r_state == S_SQ);
    assign hist_we     = (r_state == S_HSUM);

    cmm_ram #(.WIDTH(TBLW), .DEPTH(COLOR_ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (i_entry_slot[TAW-1:0]),
        .i_wdata ({i_entry_red, i_entry_green, i_entry_blue}),
        .i_re    (tbl_re),
        .i_raddr (r_idx[TAW-1:0]),
        .o_rdata (tbl_rdata)
    );

    cmm_ram #(.WIDTH(MAG_W), .DEPTH(HISTORY_DEPTH)) u_history (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_hptr),
        .i_wdata (mag),
        .i_re    (hist_re),
        .i_raddr (r_hptr),
        .o_rdata (hist_rdata)
    );

    // one restoring step per lane
    always_comb begin
        logic [RAW_W:0] t;
        logic           ge;
        for (int k = 0; k < 3; k++) begin
            t  = {r_rem[k], r_dvd[k][DVDW-1]};
            ge = t >= {1'b0, r_dsr[k]};
            n_rem[k] = ge ? RAW_W'(t - {1'b0, r_dsr[k]}) : t[RAW_W-1:0];
            n_dvd[k] = {r_dvd[k][DVDW-2:0], ge};
            sat[k]   = (|r_dvd[k][DVDW-1:NORM_W]) ? {NORM_W{1'b1}} : r_dvd[k][NORM_W-1:0];
        end
    end

    assign root_try = r_res + r_bit;
    assign mag      = r_res[MAG_W-1:0];
    assign old_mag  = r_old_v ? hist_rdata : '0;
    assign sum_new  = r_hsum - {{(SUMW-MAG_W){1'b0}}, old_mag}
                             + {{(SUMW-MAG_W){1'b0}}, mag};
    // q = sum / HISTORY_DEPTH by reciprocal multiplication
    assign q_prod   = {{QSH{1'b0}}, r_hsum} * {{SUMW{1'b0}}, QSH'(QMUL)};
    // 9*q + m, then divide by 10 by reciprocal multiplication
    assign avg_dvd  = {1'b0, r_q, 3'b000} + {4'b0, r_q} + {4'b0, mag};
    assign a_prod   = {{ASH{1'b0}}, avg_dvd} * {{AVW{1'b0}}, ASH'(AMUL)};
    assign avg      = a_prod[ASH +: MAG_W];
    assign diff     = (mag > r_avg) ? mag - r_avg : r_avg - mag;

    assign ent[0] = tbl_rdata[TBLW-1 -: NORM_W];
    assign ent[1] = tbl_rdata[2*NORM_W-1 -: NORM_W];
    assign ent[2] = tbl_rdata[NORM_W-1:0];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ad[k] = (r_n[k] > ent[k]) ? r_n[k] - ent[k] : ent[k] - r_n[k];
        end
    end
    assign d2 = {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};

    assign out_free = !r_o_valid || i_out_ready;
    assign can_push = !r_pend_v || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale   <= FULL_SCALE_RST;
            r_match_limit  <= '0;
            r_match_enable <= 1'b0;
            r_delta_enable <= 1'b0;
            r_delta_limit  <= '0;
            r_state        <= S_IDLE;
            r_hsum         <= '0;
            r_hptr         <= '0;
            r_pend_v       <= 1'b0;
            r_o_valid      <= 1'b0;
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                r_hval[k] <= 1'b0;
            end
            for (int k = 0; k < COLOR_ENTRIES; k++) begin
                r_tval[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FULL_SCALE:   r_full_scale   <= i_cfg_data;
                    CFG_MATCH_LIMIT:  r_match_limit  <= i_cfg_data[LIMIT_W-1:0];
                    CFG_MATCH_ENABLE: r_match_enable <= i_cfg_data[0];
                    CFG_DELTA_ENABLE: r_delta_enable <= i_cfg_data[0];
                    CFG_DELTA_LIMIT:  r_delta_limit  <= i_cfg_data[DLIM_W-1:0];
                    default: ;
                endcase
            end

            // drop the output once taken; loads below override
            if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_opcode == OP_STORE) begin
                            if (store_hit) begin
                                r_tval[i_entry_slot[TAW-1:0]] <= i_entry_valid;
                            end
                        end else begin
                            r_dvd[0] <= {i_raw_red, 8'd0} - {8'd0, i_raw_red};
                            r_dvd[1] <= {i_raw_green, 8'd0} - {8'd0, i_raw_green};
                            r_dvd[2] <= {i_raw_blue, 8'd0} - {8'd0, i_raw_blue};
                            for (int k = 0; k < 3; k++) begin
                                r_rem[k] <= '0;
                                r_dsr[k] <= r_full_scale;
                            end
                            r_lim2   <= r_match_limit * r_match_limit;
                            r_report <= !r_delta_enable;
                            r_cnt    <= '0;
                            r_state  <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    for (int k = 0; k < 3; k++) begin
                        r_dvd[k] <= n_dvd[k];
                        r_rem[k] <= n_rem[k];
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(DIV_STEPS - 1)) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    // normalized values settle here; fetch the oldest magnitude
                    for (int k = 0; k < 3; k++) begin
                        r_n[k] <= sat[k];
                    end
                    r_sx    <= RTW'(sat[0]) * RTW'(sat[0]) + RTW'(sat[1]) * RTW'(sat[1])
                             + RTW'(sat[2]) * RTW'(sat[2]);
                    r_res   <= '0;
                    r_bit   <= RTW'(1) << 18;
                    r_old_v <= r_hval[r_hptr];
                    r_cnt   <= '0;
                    if (r_delta_enable) begin
                        r_state <= S_ROOT;
                    end else if (r_match_enable) begin
                        r_idx   <= '0;
                        r_state <= S_MRD;
                    end else begin
                        r_state <= S_REP;
                    end
                end
                S_ROOT: begin
                    if (r_sx >= root_try) begin
                        r_sx  <= r_sx - root_try;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(ROOT_STEPS - 1)) begin
                        r_state <= S_HSUM;
                    end
                end
                S_HSUM: begin
                    r_hsum         <= sum_new;
                    r_hval[r_hptr] <= 1'b1;
                    r_hptr         <= (r_hptr == HAW'(HISTORY_DEPTH - 1)) ? '0 : r_hptr + 1'b1;
                    r_state        <= S_DIVQ;
                end
                S_DIVQ: begin
                    r_q     <= q_prod[QSH +: MAG_W];
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    r_avg   <= avg;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_report <= diff > r_delta_limit;
                    r_idx    <= '0;
                    r_state  <= r_match_enable ? S_MRD : S_REP;
                end
                S_MRD: begin
                    r_state <= (r_idx == TIW'(COLOR_ENTRIES)) ? S_REP : S_MSQ;
                end
                S_MSQ: begin
                    for (int k = 0; k < 3; k++) begin
                        r_sq[k] <= ad[k] * ad[k];
                    end
                    r_state <= S_MCMP;
                end
                S_MCMP: begin
                    if (!(r_tval[r_idx[TAW-1:0]] && d2 < {2'b00, r_lim2})) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_MRD;
                    end else if (can_push) begin
                        // hold the new match; the previous one leaves as not last
                        if (r_pend_v) begin
                            r_o_valid <= 1'b1;
                            r_o_kind  <= r_pend_kind;
                            r_o_slot  <= r_pend_slot;
                            r_o_last  <= 1'b0;
                            for (int k = 0; k < 3; k++) begin
                                r_o_n[k] <= r_n[k];
                            end
                        end
                        r_pend_v    <= 1'b1;
                        r_pend_kind <= KIND_MATCH;
                        r_pend_slot <= SLOT_W'(r_idx[TAW-1:0]);
                        r_idx       <= r_idx + 1'b1;
                        r_state     <= S_MRD;
                    end
                end
                S_REP: begin
                    if (!r_report) begin
                        r_state <= S_FIN;
                    end else if (can_push) begin
                        if (r_pend_v) begin
                            r_o_valid <= 1'b1;
                            r_o_kind  <= r_pend_kind;
                            r_o_slot  <= r_pend_slot;
                            r_o_last  <= 1'b0;
                            for (int k = 0; k < 3; k++) begin
                                r_o_n[k] <= r_n[k];
                            end
                        end
                        r_pend_v    <= 1'b1;
                        r_pend_kind <= KIND_REPORT;
                        r_pend_slot <= '0;
                        r_state     <= S_FIN;
                    end
                end
                S_FIN: begin
                    // release the held result as the final one
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= r_pend_kind;
                        r_o_slot  <= r_pend_slot;
                        r_o_last  <= 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            r_o_n[k] <= r_n[k];
                        end
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_norm_red     = r_o_n[0];
    assign o_norm_green   = r_o_n[1];
    assign o_norm_blue    = r_o_n[2];
    assign o_matched_slot = r_o_slot;
    assign o_last         = r_o_last;

    `ASSERT_IMPL(a_idle_no_pending, i_clk, i_rst_n, o_in_ready, !r_pend_v)
    `ASSERT_IMPL(a_report_slot_zero, i_clk, i_rst_n,
        o_out_valid && (o_kind == KIND_REPORT), o_matched_slot == '0)
    `ASSERT_NEXT(a_store_one_cycle, i_clk, i_rst_n,
        in_acc && (i_opcode == OP_STORE), o_in_ready)
    `ASSERT_IMPL(a_hptr_range, i_clk, i_rst_n, 1'b1,
        {1'b0, r_hptr} < (HAW+1)'(HISTORY_DEPTH))
endmodule

// ----- bench/tb_color_measure_match.sv -----
module tb_color_measure_match;
    import cmm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS = 16;
    localparam int HIST_N = 16;
    localparam int RANDOM_ITEMS = 440;
    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_opcode = 1'b0;
    logic [RAW_W-1:0] i_raw_red = '0, i_raw_green = '0, i_raw_blue = '0;
    logic [SLOT_W-1:0] i_entry_slot = '0;
    logic [NORM_W-1:0] i_entry_red = '0, i_entry_green = '0, i_entry_blue = '0;
    logic i_entry_valid = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_kind;
    logic [NORM_W-1:0] o_norm_red, o_norm_green, o_norm_blue;
    logic [SLOT_W-1:0] o_matched_slot;
    logic o_last;

    color_measure_match dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    typedef struct packed {
        logic              kind;
        logic [NORM_W-1:0] red;
        logic [NORM_W-1:0] green;
        logic [NORM_W-1:0] blue;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_color_result;

    typedef struct {
        logic              opcode;
        logic [RAW_W-1:0]  raw_r, raw_g, raw_b;
        logic [SLOT_W-1:0] slot;
        logic [NORM_W-1:0] er, eg, eb;
        logic              ev;
        bit                typed;  // hand-written expectation follows
        t_color_result     known;
    } t_color_op;

    // Shadow of the block's registers and memories.
    logic [RAW_W-1:0]   sh_full_scale;
    logic [LIMIT_W-1:0] sh_match_limit;
    logic               sh_match_en, sh_delta_en;
    logic [DLIM_W-1:0]  sh_delta_limit;
    logic [NORM_W-1:0]  sh_tr [N_SLOTS], sh_tg [N_SLOTS], sh_tb [N_SLOTS];
    logic               sh_tv [N_SLOTS];
    int unsigned        sh_hist [HIST_N];
    int unsigned        sh_hsum, sh_hptr;

    t_color_result pending_results[$];
    int n_mismatch = 0;
    int unsigned n_cycles = 0;
    bit tail_phase = 0;  // no idling near the end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("color_measure_match regression: fail");
            $finish;
        end
    end

    function automatic logic [NORM_W-1:0] scale_reading(logic [RAW_W-1:0] raw);
        int unsigned v;
        if (sh_full_scale == 0) return 8'd255;
        v = (raw * 255) / sh_full_scale;
        return (v > 255) ? 8'd255 : v[NORM_W-1:0];
    endfunction

    function automatic int unsigned int_root(int unsigned x);
        int unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= x) r++;
        return r;
    endfunction

    // Work out the results of one transaction and advance the shadow state.
    function automatic void predict_color(t_color_op op);
        logic [NORM_W-1:0] r, g, b;
        int unsigned mag, avg, dev, lim2, d2;
        int dr, dg, db;
        t_color_result res;
        int first;
        dev = 0;
        if (op.opcode == OP_STORE) begin
            sh_tr[op.slot] = op.er;
            sh_tg[op.slot] = op.eg;
            sh_tb[op.slot] = op.eb;
            sh_tv[op.slot] = op.ev;
            return;
        end
        r = scale_reading(op.raw_r);
        g = scale_reading(op.raw_g);
        b = scale_reading(op.raw_b);
        first = pending_results.size();
        if (sh_delta_en) begin
            mag = int_root(int'(r) * int'(r) + int'(g) * int'(g) + int'(b) * int'(b));
            sh_hsum = sh_hsum - sh_hist[sh_hptr] + mag;
            sh_hist[sh_hptr] = mag;
            sh_hptr = (sh_hptr + 1) % HIST_N;
            avg = (9 * (sh_hsum / HIST_N) + mag) / 10;
            dev = (mag > avg) ? mag - avg : avg - mag;
        end
        res = '{kind: KIND_MATCH, red: r, green: g, blue: b, slot: '0, last: 1'b0};
        if (sh_match_en) begin
            lim2 = sh_match_limit * sh_match_limit;
            for (int i = 0; i < N_SLOTS; i++) begin
                if (!sh_tv[i]) continue;
                dr = int'(r) - int'(sh_tr[i]);
                dg = int'(g) - int'(sh_tg[i]);
                db = int'(b) - int'(sh_tb[i]);
                d2 = dr * dr + dg * dg + db * db;
                if (d2 < lim2) begin
                    res.slot = i[SLOT_W-1:0];
                    pending_results.push_back(res);
                end
            end
        end
        if (!sh_delta_en || dev > sh_delta_limit) begin
            res.kind = KIND_REPORT;
            res.slot = '0;
            pending_results.push_back(res);
        end
        if (pending_results.size() > first)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    // Result side: random stalls, compare against the oldest expectation.
    initial begin
        int stall;
        t_color_result got, want;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!tail_phase && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                stall = $urandom_range(1, 10);
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got = '{o_kind, o_norm_red, o_norm_green, o_norm_blue,
                        o_matched_slot, o_last};
                if (pending_results.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result %p", got);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    // Write one register while the block is idle; mirror it in the shadow.
    task automatic write_reg(logic [CFG_IW-1:0] idx, int unsigned val);
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DW-1:0];
        i_cfg_valid <= 1'b1;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FULL_SCALE:   sh_full_scale = val[RAW_W-1:0];
            CFG_MATCH_LIMIT:  sh_match_limit = val[LIMIT_W-1:0];
            CFG_MATCH_ENABLE: sh_match_en = val[0];
            CFG_DELTA_ENABLE: sh_delta_en = val[0];
            CFG_DELTA_LIMIT:  sh_delta_limit = val[DLIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_mode(int unsigned fs, int unsigned ml, bit me, bit de, int unsigned dl);
        write_reg(CFG_FULL_SCALE, fs);
        write_reg(CFG_MATCH_LIMIT, ml);
        write_reg(CFG_MATCH_ENABLE, me);
        write_reg(CFG_DELTA_ENABLE, de);
        write_reg(CFG_DELTA_LIMIT, dl);
    endtask

    // Hold off until every expected result has come, then let the block settle
    // (a store or a measure that gives no result leaves nothing to wait for, so add its worst-case latency).
    task automatic drain_results();
        wait (pending_results.size() == 0);
        repeat (150) @(posedge i_clk);
    endtask

    // Drive one transaction; valid stays high across back-to-back items.
    task automatic send_op(t_color_op op);
        int gap;
        if (!tail_phase && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge i_clk);
        end
        i_opcode <= op.opcode;
        i_raw_red <= op.raw_r;
        i_raw_green <= op.raw_g;
        i_raw_blue <= op.raw_b;
        i_entry_slot <= op.slot;
        i_entry_red <= op.er;
        i_entry_green <= op.eg;
        i_entry_blue <= op.eb;
        i_entry_valid <= op.ev;
        i_in_valid <= 1'b1;
        @(posedge i_clk iff o_in_ready);
        if (op.typed) begin
            pending_results.push_back(op.known);
        end else begin
            predict_color(op);
        end
    endtask

    function automatic t_color_op measure_op(int unsigned r, int unsigned g, int unsigned b);
        t_color_op op;
        op = '{OP_MEASURE, RAW_W'(r), RAW_W'(g), RAW_W'(b), '0, '0, '0, '0, 1'b0, 1'b0, '0};
        return op;
    endfunction

    function automatic t_color_op store_op(int unsigned s, int unsigned r, int unsigned g,
                                           int unsigned b, bit v);
        t_color_op op;
        op = '{OP_STORE, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
               SLOT_W'(s), NORM_W'(r), NORM_W'(g), NORM_W'(b), v, 1'b0, '0};
        return op;
    endfunction

    function automatic t_color_op random_op();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return store_op($urandom_range(0, 15), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 3) != 0);
        if (pick < 5)
            return measure_op($urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 4095));
        // near each other around mid-scale, so matches and departures happen
        return measure_op($urandom_range(1800, 2300), $urandom_range(1800, 2300),
                          $urandom_range(1800, 2300));
    endfunction

    t_color_op stim_table[$];

    initial begin
        t_color_op op;
        sh_full_scale = FULL_SCALE_RST;
        sh_match_limit = '0;
        sh_match_en = 1'b0;
        sh_delta_en = 1'b0;
        sh_delta_limit = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
            sh_tr[i] = '0; sh_tg[i] = '0; sh_tb[i] = '0; sh_tv[i] = 1'b0;
        end
        for (int i = 0; i < HIST_N; i++) sh_hist[i] = 0;
        sh_hsum = 0;
        sh_hptr = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: reset defaults report every measurement unchanged.
        op = measure_op(0, 0, 0);
        op.typed = 1;
        op.known = '{KIND_REPORT, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1};
        stim_table.push_back(op);
        op = measure_op(4095, 4095, 4095);
        op.typed = 1;
        op.known = '{KIND_REPORT, 8'd255, 8'd255, 8'd255, 4'd0, 1'b1};
        stim_table.push_back(op);
        stim_table.push_back(measure_op(12'hAAA, 12'h555, 12'h800));
        foreach (stim_table[i]) send_op(stim_table[i]);
        stim_table.delete();
        i_in_valid <= 1'b0;
        drain_results();

        // Zero full scale saturates everything.
        set_mode(0, 255, 1, 0, 0);
        op = measure_op(0, 1, 4095);
        op.typed = 1;
        op.known = '{KIND_REPORT, 8'd255, 8'd255, 8'd255, 4'd0, 1'b1};
        stim_table.push_back(op);
        stim_table.push_back(store_op(0, 255, 255, 255, 1));
        stim_table.push_back(store_op(15, 0, 0, 0, 1));
        stim_table.push_back(store_op(7, 250, 255, 255, 1));
        stim_table.push_back(store_op(3, 255, 255, 255, 0));
        stim_table.push_back(measure_op(100, 200, 300));
        foreach (stim_table[i]) send_op(stim_table[i]);
        stim_table.delete();
        i_in_valid <= 1'b0;
        drain_results();

        // Small full scale: readings above it saturate; delta mode on.
        set_mode(1000, 10, 1, 1, 0);
        stim_table.push_back(measure_op(0, 0, 0));
        stim_table.push_back(measure_op(1000, 999, 4095));
        stim_table.push_back(measure_op(1, 500, 2000));
        stim_table.push_back(store_op(15, 128, 128, 128, 1));
        stim_table.push_back(measure_op(502, 502, 502));
        stim_table.push_back(measure_op(0, 0, 0));
        foreach (stim_table[i]) send_op(stim_table[i]);
        stim_table.delete();
        i_in_valid <= 1'b0;
        drain_results();

        set_mode(4095, 0, 1, 1, 511);
        stim_table.push_back(measure_op(4095, 0, 4095));
        stim_table.push_back(measure_op(2048, 2048, 2048));
        foreach (stim_table[i]) send_op(stim_table[i]);
        stim_table.delete();
        i_in_valid <= 1'b0;
        drain_results();

        // Random phases, each with its own setting.
        for (int phase = 0; phase < 8; phase++) begin
            set_mode($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                               : $urandom_range(2048, 4095),
                     $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 80),
                     $urandom_range(0, 3) != 0, $urandom_range(0, 1),
                     $urandom_range(0, 3) == 0 ? 511 : $urandom_range(0, 30));
            if (phase == 7) tail_phase = 1;
            for (int k = 0; k < RANDOM_ITEMS / 8; k++) send_op(random_op());
            i_in_valid <= 1'b0;
            drain_results();
        end

        if (n_mismatch == 0 && pending_results.size() == 0)
            $display("color_measure_match regression: pass");
        else
            $display("color_measure_match regression: fail");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/cmm_pkg.sv
sv/cmm_ram.sv
sv/color_measure_match.sv
bench/tb_color_measure_match.sv
